// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the transliterator RTL.
// Each check is clocked on the rising edge and is ignored while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DNT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger in one cycle implies a consequence in the same cycle.
`define DNT_ASSERT_IMPL(label, clk, rst_n, trig, cons, msg) \
	`DNT_ASSERT(label, clk, rst_n, (trig) |-> (cons), msg)

// Check that a trigger in one cycle implies a consequence in the next cycle.
`define DNT_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	`DNT_ASSERT(label, clk, rst_n, (trig) |=> (cons), msg)

`endif

// ----- hw/rtl/dnt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnt_pkg
// Types, character codes and the umlaut and sharp-s lookup for the name transliterator.
// ----------------------------------------------------------------------------
package dnt_pkg;

	localparam logic [7:0] LEAD_BYTE  = 8'hC3;
	localparam logic [7:0] UML_A_LO   = 8'hA4;
	localparam logic [7:0] UML_A_UP   = 8'h84;
	localparam logic [7:0] UML_O_LO   = 8'hB6;
	localparam logic [7:0] UML_O_UP   = 8'h96;
	localparam logic [7:0] UML_U_LO   = 8'hBC;
	localparam logic [7:0] UML_U_UP   = 8'h9C;
	localparam logic [7:0] SHARP_S    = 8'h9F;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAREN   = 8'h28;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_E    = 8'h45;
	localparam logic [7:0] CH_UP_O    = 8'h4F;
	localparam logic [7:0] CH_UP_S    = 8'h53;
	localparam logic [7:0] CH_UP_U    = 8'h55;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_Z    = 8'h7A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	localparam logic       REG_OUT_CAPACITY = 1'b0;
	localparam logic [8:0] CAP_RESET        = 9'd32;
	localparam logic [9:0] CAP_MAX          = 10'd256;

	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] idx;
		logic       is_len;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] c1;
		logic [7:0] c2;
	} pair_t;

	// Second byte after the lead: map to a two-letter substitution.
	function automatic pair_t pair_lookup(input logic [7:0] b);
		pair_t p;
		p = '0;
		case (b)
			UML_A_LO, UML_A_UP: p = '{hit: 1'b1, c1: CH_UP_A, c2: CH_UP_E};
			UML_O_LO, UML_O_UP: p = '{hit: 1'b1, c1: CH_UP_O, c2: CH_UP_E};
			UML_U_LO, UML_U_UP: p = '{hit: 1'b1, c1: CH_UP_U, c2: CH_UP_E};
			SHARP_S:            p = '{hit: 1'b1, c1: CH_UP_S, c2: CH_UP_S};
			default:            p = '0;
		endcase
		return p;
	endfunction

endpackage

// ----- hw/rtl/display_name_transliterator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_name_transliterator
// Path: an accepted word is held in the input register, then written into the output queue.
// Throughput: one input word per cycle for single-byte results while the output accepts; a
//   two-letter substitution puts two words on the one output stream, and input stalls without room for two.
// The rate is set by the output queue, which takes up to two results per cycle, gives one.
// Reset (arst_n low, asynchronous): state cleared, capacity back to 32, queue empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module display_name_transliterator import dnt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_string
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] index_or_length
	output logic        m_tuser,   // is_length
	output logic        m_tlast,   // last
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ------------------------------------------------------------------
	// Configuration register. Register index is the word address bit.
	// ------------------------------------------------------------------
	logic [8:0] cap_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OUT_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[8:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_OUT_CAPACITY) begin
			prdata = {23'd0, cap_q};
		end
	end

	// ------------------------------------------------------------------
	// Input register: one word, freed as soon as the queue has room for
	// the two results it may cause.
	// ------------------------------------------------------------------
	logic                s1_valid;
	logic [7:0]          byte_s1;
	logic                eos_s1;
	logic                s1_go;
	logic [OQ_AW:0]      oq_cnt_q;

	assign s1_go    = s1_valid && (oq_cnt_q <= (OQ_AW+1)'(OQ_DEPTH - 2));
	assign s_tready = !s1_valid || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Name state
	// ------------------------------------------------------------------
	logic       stop_q, lead_q;
	logic [7:0] wc_q, ns_q;
	logic       stop_d, lead_d;
	logic [7:0] wc_d, ns_d;
	logic [1:0] n_res;
	out_word_t  w0, w1;
	logic [9:0] cap_eff, wc_p1, wc_p2;
	pair_t      pr;

	// Capacity above 256 behaves as 256, so indices stay in 8 bits.
	assign cap_eff = ({1'b0, cap_q} > CAP_MAX) ? CAP_MAX : {1'b0, cap_q};
	assign wc_p1   = {2'b00, wc_q} + 10'd1;
	assign wc_p2   = {2'b00, wc_q} + 10'd2;
	assign pr      = pair_lookup(byte_s1);

	always_comb begin
		stop_d = stop_q;
		lead_d = lead_q;
		wc_d   = wc_q;
		ns_d   = ns_q;
		n_res  = 2'd0;
		w0     = '0;
		w1     = '0;
		if (eos_s1) begin
			// Terminator: report trimmed length, start a fresh name.
			w0     = '{data: 8'd0, idx: ns_q, is_len: 1'b1, last: 1'b0};
			n_res  = 2'd1;
			stop_d = 1'b0;
			lead_d = 1'b0;
			wc_d   = '0;
			ns_d   = '0;
		end else if (lead_q) begin
			// Second byte of a lead pair is always consumed here.
			lead_d = 1'b0;
			if (pr.hit && (wc_p1 < cap_eff)) begin
				w0    = '{data: pr.c1, idx: wc_q, is_len: 1'b0, last: 1'b0};
				n_res = 2'd1;
				wc_d  = wc_p1[7:0];
				ns_d  = wc_p1[7:0];
				// Pair may be cut to its first letter by the capacity.
				if (wc_p2 < cap_eff) begin
					w1    = '{data: pr.c2, idx: wc_p1[7:0], is_len: 1'b0, last: 1'b0};
					n_res = 2'd2;
					wc_d  = wc_p2[7:0];
					ns_d  = wc_p2[7:0];
				end
			end
		end else if (!stop_q) begin
			if ((wc_p2 >= cap_eff) || (byte_s1 == CH_PAREN)) begin
				stop_d = 1'b1;
			end else if (byte_s1 == LEAD_BYTE) begin
				lead_d = 1'b1;
			end else if (byte_s1 inside {[CH_LO_A:CH_LO_Z]}) begin
				w0    = '{data: byte_s1 - CASE_DELTA, idx: wc_q, is_len: 1'b0, last: 1'b0};
				n_res = 2'd1;
				wc_d  = wc_p1[7:0];
				ns_d  = wc_p1[7:0];
			end else if (byte_s1 inside {[CH_UP_A:CH_UP_Z], [CH_ZERO:CH_NINE],
					CH_SPACE, CH_HYPHEN, CH_SLASH}) begin
				w0    = '{data: byte_s1, idx: wc_q, is_len: 1'b0, last: 1'b0};
				n_res = 2'd1;
				wc_d  = wc_p1[7:0];
				// Spaces do not extend the trimmed length.
				if (byte_s1 != CH_SPACE) begin
					ns_d = wc_p1[7:0];
				end
			end
		end
		// Flag the final result of this word.
		if (n_res == 2'd1) begin
			w0.last = 1'b1;
		end
		if (n_res == 2'd2) begin
			w1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
			lead_q <= 1'b0;
			wc_q   <= '0;
			ns_q   <= '0;
		end else if (s1_go) begin
			stop_q <= stop_d;
			lead_q <= lead_d;
			wc_q   <= wc_d;
			ns_q   <= ns_d;
		end
	end

	// ------------------------------------------------------------------
	// Output queue: push up to two words, pop one.
	// ------------------------------------------------------------------
	out_word_t         oq_mem [OQ_DEPTH];
	logic [OQ_AW-1:0]  oq_head_q, oq_tail_q, oq_tail_p1;
	logic              oq_pop;
	logic [1:0]        n_push;
	out_word_t         head_w;

	assign n_push     = s1_go ? n_res : 2'd0;
	assign oq_pop     = m_tvalid && m_tready;
	assign oq_tail_p1 = oq_tail_q + OQ_AW'(1);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			oq_mem[oq_tail_q] <= w0;
		end
		if (n_push == 2'd2) begin
			oq_mem[oq_tail_p1] <= w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_head_q <= '0;
			oq_tail_q <= '0;
			oq_cnt_q  <= '0;
		end else begin
			oq_tail_q <= oq_tail_q + OQ_AW'(n_push);
			if (oq_pop) begin
				oq_head_q <= oq_head_q + OQ_AW'(1);
			end
			oq_cnt_q <= oq_cnt_q + (OQ_AW+1)'(n_push) - (OQ_AW+1)'(oq_pop);
		end
	end

	assign head_w   = oq_mem[oq_head_q];
	assign m_tvalid = (oq_cnt_q != '0);
	assign m_tdata  = {head_w.idx, head_w.data};
	assign m_tuser  = head_w.is_len;
	assign m_tlast  = head_w.last;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`DNT_ASSERT(a_oq_bound, clk, arst_n, oq_cnt_q <= (OQ_AW+1)'(OQ_DEPTH), "output queue overflow")
	`DNT_ASSERT_IMPL(a_len_last, clk, arst_n, m_tvalid && m_tuser, m_tlast && (m_tdata[7:0] == 8'd0), "length word not last or nonzero byte")
	`DNT_ASSERT(a_ns_le_wc, clk, arst_n, ns_q <= wc_q, "trimmed length beyond write count")
	`DNT_ASSERT_NEXT(a_eos_clear, clk, arst_n, s1_go && eos_s1, (wc_q == 8'd0) && !lead_q && !stop_q, "terminator did not clear state")

endmodule
